@@ rtl/sicr_pkg.sv @@
// ----------------------------------------------------------------------------
// sicr_pkg
// Types, constants and helpers shared by the serial command responder.
// ----------------------------------------------------------------------------
package sicr_pkg;

  localparam int PKT_BYTES  = 4;   // packet slots in use (2..4)
  localparam int VPIN_COUNT = 64;  // virtual pins held in the value store
  localparam int VPIN_AW    = 6;   // address bits of the value store
  localparam int MAX_RES    = 5;   // most results one received byte can cause
  localparam int CNT_W      = 3;   // holds 0..MAX_RES
  localparam int ID_W       = 4;

  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_DDRIVE = 2'd1,
    KIND_ADRIVE = 2'd2
  } kind_t;

  typedef logic [3:0][7:0] pkt_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx;
    logic [6:0]  pin;
    logic [13:0] value;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_list_t;

  // Write request into the virtual pin store.
  typedef struct packed {
    logic               en;
    logic [VPIN_AW-1:0] addr;
    logic [13:0]        data;
  } vwr_t;

  function automatic res_t mk_reply(input logic [7:0] tx);
    res_t r;
    r.kind  = KIND_REPLY;
    r.tx    = tx;
    r.pin   = '0;
    r.value = '0;
    return r;
  endfunction

  function automatic res_t mk_drive(input kind_t kind, input logic [6:0] pin,
                                    input logic [13:0] value);
    res_t r;
    r.kind  = kind;
    r.tx    = '0;
    r.pin   = pin;
    r.value = value;
    return r;
  endfunction

endpackage

@@ rtl/sicr_frame.sv @@
// ----------------------------------------------------------------------------
// sicr_frame
// Packet framing: collects received bytes into the packet slots and returns
// the slots as they stand after the current byte.
// ----------------------------------------------------------------------------
module sicr_frame import sicr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output pkt_t       pkt_snap,
  output logic       pkt_end
);

  localparam logic [1:0] LAST_SLOT = 2'(PKT_BYTES - 1);

  pkt_t       pkt_r, pkt_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [1:0] pos_c;

  assign pos_c = (pos_r > LAST_SLOT) ? LAST_SLOT : pos_r;

  always_comb begin
    pkt_nxt = pkt_r;
    pos_nxt = pos_r;
    if (accept) begin
      if (rx_byte[7]) begin
        // End byte: drop the end flag and clear the slots after it.
        for (int i = 0; i < 4; i++) begin
          if (2'(i) == pos_c) begin
            pkt_nxt[i] = {1'b0, rx_byte[6:0]};
          end else if (2'(i) > pos_c) begin
            pkt_nxt[i] = '0;
          end
        end
        pos_nxt = '0;
      end else begin
        pkt_nxt[pos_c] = rx_byte;
        pos_nxt = (pos_c < LAST_SLOT) ? pos_c + 2'd1 : pos_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r <= '0;
      pos_r <= '0;
    end else begin
      pkt_r <= pkt_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign pkt_snap = pkt_nxt;
  assign pkt_end  = rx_byte[7];

endmodule

@@ rtl/sicr_exec.sv @@
// ----------------------------------------------------------------------------
// sicr_exec
// Command decode: turns one framed packet into its drive action, its store
// write and its reply bytes.
// ----------------------------------------------------------------------------
module sicr_exec import sicr_pkg::*; (
  input  pkt_t             pkt,
  input  logic             pkt_end,
  input  logic [ID_W-1:0]  own_id,
  input  logic [63:0]      pin_levels,
  input  logic [9:0]       analog_sample,
  input  logic [13:0]      vpin_value,
  output res_list_t        res_list,
  output logic [CNT_W-1:0] res_cnt,
  output vwr_t             vwr
);

  logic [7:0]       b0, b1, b2, b3;
  logic [7:0]       r1, r2, r3;
  logic [13:0]      val;
  logic             vidx_ok;
  logic [CNT_W-1:0] n;

  assign b0 = pkt[0];
  assign b1 = pkt[1];
  assign b2 = pkt[2];
  assign b3 = pkt[3];
  assign vidx_ok = 7'(b1[5:0]) < 7'(VPIN_COUNT);

  always_comb begin
    res_list = '0;
    vwr      = '0;
    n        = '0;
    r1       = b1;
    r2       = b2;
    r3       = b3;
    val      = '0;
    if (pkt_end && !b0[4] && (b0[3:0] == own_id)) begin
      if (b0[6]) begin
        if (b0[5]) begin
          r1 = {1'b1, pin_levels[b1[5:0]], b1[5:0]};
        end else begin
          res_list[n] = mk_drive(KIND_DDRIVE, {1'b0, b1[5:0]}, {13'b0, b1[6]});
          n = n + 1'b1;
          r1 = {1'b1, b1[6:0]};
        end
      end else if (b0[5]) begin
        // Pins 64 and up are virtual and come from the store.
        if (b1[6]) begin
          val = vidx_ok ? vpin_value : '0;
        end else begin
          val = {4'b0, analog_sample};
        end
        if (val > 14'h7F) begin
          r2 = {1'b0, val[6:0]};
          r3 = {1'b1, val[13:7]};
        end else begin
          r2 = {1'b1, val[6:0]};
          r3 = '0;
        end
      end else begin
        val = {b3[6:0], b2[6:0]};
        if (b1[6]) begin
          vwr.en   = vidx_ok;
          vwr.addr = b1[5:0];
          vwr.data = val;
        end else begin
          res_list[n] = mk_drive(KIND_ADRIVE, b1[6:0], val);
          n = n + 1'b1;
        end
      end
      res_list[n] = mk_reply(b0 | 8'h10);
      n = n + 1'b1;
      res_list[n] = mk_reply(r1);
      n = n + 1'b1;
      if (r2 != 8'h00) begin
        res_list[n] = mk_reply(r2);
        n = n + 1'b1;
      end
      if (r3 != 8'h00) begin
        res_list[n] = mk_reply(r3);
        n = n + 1'b1;
      end
    end
    res_cnt = n;
  end

endmodule

@@ rtl/serial_io_command_responder_unit.sv @@
// ----------------------------------------------------------------------------
// serial_io_command_responder_unit
// Frames received serial bytes into command packets, executes the ones
// addressed to this node and emits drive actions and reply bytes.
//
// Usage:
// - Input channel (in_*): one received byte per transfer, together with the
//   current pin levels and converter sample used if that byte ends a packet.
// - Result channel (out_*): one result per transfer; out_last marks the final
//   result caused by an input byte. Bytes that cause no result give none.
// - cfg_wr_en/cfg_wr_data set the node ID; write only while the block is idle.
// Each byte is held in the input register and its results then in the result
// register, which sends them one at a time over the single result port (none,
// or two to five per byte). The next byte is taken while the results of the
// previous one are still being delivered.
// Reset (synchronous, active low) clears the packet slots, the node ID and
// the virtual pin store (per-entry valid bits, no clearing pass).
// When out_stall is high the current result holds, and once the byte in the
// input register is waiting too, in_stall rises.
// ----------------------------------------------------------------------------
module serial_io_command_responder_unit import sicr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic [63:0]       in_pin_levels,
  input  logic [9:0]        in_analog_sample,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_result_kind,
  output logic [7:0]        out_tx_byte,
  output logic [6:0]        out_pin_number,
  output logic [13:0]       out_drive_value,
  output logic              out_last,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [ID_W-1:0]   cfg_wr_data
);

  logic [ID_W-1:0]     own_id_r;

  logic                in_xfer, out_xfer, s1_adv;
  pkt_t                pkt_snap;
  logic                pkt_end;
  logic [VPIN_AW-1:0]  rd_addr;

  // Input register
  logic                s1_valid_r;
  pkt_t                s1_pkt_r;
  logic                s1_end_r;
  logic [63:0]         s1_levels_r;
  logic [9:0]          s1_sample_r;
  logic [13:0]         s1_mem_r;
  logic                s1_vld_r;
  logic                s1_fwd_r;
  logic [13:0]         s1_fwd_data_r;
  logic [13:0]         vpin_value;

  // Virtual pin store
  logic [13:0]         vmem [VPIN_COUNT];
  logic [VPIN_COUNT-1:0] vld_r;

  // Result register
  res_list_t           ent_r;
  logic [CNT_W-1:0]    cnt_r;

  res_list_t           res_list;
  logic [CNT_W-1:0]    res_cnt;
  vwr_t                vwr;

  assign out_valid = (cnt_r != '0);
  assign out_xfer  = out_valid && !out_stall;
  assign s1_adv    = s1_valid_r && ((cnt_r == '0) || (out_xfer && (cnt_r == CNT_W'(1))));
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
    end else if (cfg_wr_en) begin
      own_id_r <= cfg_wr_data;
    end
  end

  sicr_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_xfer),
    .rx_byte  (in_rx_byte),
    .pkt_snap (pkt_snap),
    .pkt_end  (pkt_end)
  );

  assign rd_addr = pkt_snap[1][VPIN_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // A store write from the byte leaving the input register is forwarded to
  // the read of the byte entering it in the same cycle.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pkt_r      <= pkt_snap;
      s1_end_r      <= pkt_end;
      s1_levels_r   <= in_pin_levels;
      s1_sample_r   <= in_analog_sample;
      s1_mem_r      <= vmem[rd_addr];
      s1_vld_r      <= vld_r[rd_addr];
      s1_fwd_r      <= s1_adv && vwr.en && (vwr.addr == rd_addr);
      s1_fwd_data_r <= vwr.data;
    end
  end

  assign vpin_value = s1_fwd_r ? s1_fwd_data_r : (s1_vld_r ? s1_mem_r : 14'd0);

  always_ff @(posedge clk) begin
    if (s1_adv && vwr.en) begin
      vmem[vwr.addr] <= vwr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (s1_adv && vwr.en) begin
      vld_r[vwr.addr] <= 1'b1;
    end
  end

  sicr_exec u_exec (
    .pkt           (s1_pkt_r),
    .pkt_end       (s1_end_r),
    .own_id        (own_id_r),
    .pin_levels    (s1_levels_r),
    .analog_sample (s1_sample_r),
    .vpin_value    (vpin_value),
    .res_list      (res_list),
    .res_cnt       (res_cnt),
    .vwr           (vwr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (s1_adv) begin
      cnt_r <= res_cnt;
    end else if (out_xfer) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Results leave from entry zero; the rest shift down after each transfer.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ent_r <= res_list;
    end else if (out_xfer) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

  assign out_result_kind = ent_r[0].kind;
  assign out_tx_byte     = ent_r[0].tx;
  assign out_pin_number  = ent_r[0].pin;
  assign out_drive_value = ent_r[0].value;
  assign out_last        = (cnt_r == CNT_W'(1));

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && vwr.en) |-> s1_end_r)
    else $error("store write from a byte that does not end a packet");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && (cnt_r == CNT_W'(1)) && !s1_valid_r) |=> (cnt_r == '0))
    else $error("results left after the last transfer");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid))
    else $error("input stalled while the result register is free");

endmodule
